>>> rtl/mlt_pkg.sv
package mlt_pkg;

  localparam int MAX_TOKEN_LEN = 32;
  localparam int LEN_W         = 6;
  localparam int KW_BYTES      = 5;
  localparam int KW_W          = 8 * KW_BYTES;
  localparam int NUM_KW        = 4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [2:0] CFG_KW_BEGIN = 3'd0;
  localparam logic [2:0] CFG_KW_END   = 3'd1;
  localparam logic [2:0] CFG_KW_READ  = 3'd2;
  localparam logic [2:0] CFG_KW_WRITE = 3'd3;

  localparam logic [KW_W-1:0] KW_BEGIN_RST = 40'd474214786402;
  localparam logic [KW_W-1:0] KW_END_RST   = 40'd6581861;
  localparam logic [KW_W-1:0] KW_READ_RST  = 40'd1684104562;
  localparam logic [KW_W-1:0] KW_WRITE_RST = 40'd435744764535;

  localparam logic [3:0] TK_IDENT  = 4'd4;
  localparam logic [3:0] TK_INTLIT = 4'd5;
  localparam logic [3:0] TK_LPAREN = 4'd6;
  localparam logic [3:0] TK_RPAREN = 4'd7;
  localparam logic [3:0] TK_SEMI   = 4'd8;
  localparam logic [3:0] TK_COMMA  = 4'd9;
  localparam logic [3:0] TK_ASSIGN = 4'd10;
  localparam logic [3:0] TK_PLUS   = 4'd11;
  localparam logic [3:0] TK_MINUS  = 4'd12;
  localparam logic [3:0] TK_EOF    = 4'd13;
  localparam logic [3:0] TK_ERROR  = 4'd14;

  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic [3:0]       kind;
    logic [LEN_W-1:0] len;
    logic [7:0]       bad;
    logic             ovf;
    logic             last;
  } tok_t;

  // keyword text stops at its first zero byte
  function automatic logic [KW_W-1:0] kw_text(input logic [KW_W-1:0] k);
    logic [KW_W-1:0] m;
    logic            live;
    m    = '0;
    live = 1'b1;
    for (int i = 0; i < KW_BYTES; i++) begin
      if (k[8*i +: 8] == 8'd0) live = 1'b0;
      if (live) m[8*i +: 8] = k[8*i +: 8];
    end
    return m;
  endfunction

endpackage

>>> rtl/micro_language_tokenizer.sv
// Streaming lexer: one character (or end-of-input mark) is taken per cycle and
// scanned in the same cycle against the current mode; the tokens it produces
// (zero, one or two) go into a 4-word result queue that drains one word per
// cycle while out_stall is low. in_stall rises while more than two words are
// queued, so a stream whose characters yield at most one token each runs at
// one character per cycle while out_stall stays low; a step that yields two
// tokens (a token closed by a delimiter with its own token, or a flush plus
// eof) puts two words into the queue. Keyword registers are stored already
// cut at their first zero byte and may be written only while the block is idle.
module micro_language_tokenizer import mlt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char,
  input  logic             in_end_of_input,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       out_token_kind,
  output logic [LEN_W-1:0] out_token_length,
  output logic [7:0]       out_bad_char,
  output logic             out_length_overflow,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [KW_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_COLON, MODE_MINUS, MODE_COMMENT
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  logic [KW_W-1:0]  prefix_r, prefix_nxt;
  logic             run_ovf_r, run_ovf_nxt;
  logic [KW_W-1:0]  kw_r [NUM_KW];

  tok_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] rd_ptr_r, wr_ptr_r;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  logic in_acc, pop;
  assign in_stall = (count_r > FIFO_CW'(FIFO_DEPTH - 2));
  assign in_acc   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic tok_t mk(input logic [3:0] k, input logic [7:0] b);
    tok_t t;
    t      = '0;
    t.kind = k;
    t.bad  = b;
    return t;
  endfunction

  // keyword lookup on the pending identifier; lowest index wins
  logic [3:0] ident_kind;
  always_comb begin
    ident_kind = TK_IDENT;
    if (run_len_r <= LEN_W'(KW_BYTES) && !run_ovf_r) begin
      for (int i = NUM_KW - 1; i >= 0; i--) begin
        if (prefix_r == kw_r[i]) ident_kind = 4'(i);
      end
    end
  end

  // token closing the pending run or operator
  logic flush_v;
  tok_t flush_tok;
  always_comb begin
    flush_v   = 1'b1;
    flush_tok = '0;
    case (mode_r)
      MODE_IDENT: begin
        flush_tok.kind = ident_kind;
        flush_tok.len  = run_len_r;
        flush_tok.ovf  = run_ovf_r;
      end
      MODE_NUMBER: begin
        flush_tok.kind = TK_INTLIT;
        flush_tok.len  = run_len_r;
        flush_tok.ovf  = run_ovf_r;
      end
      MODE_COLON: flush_tok = mk(TK_ERROR, CH_COLON);
      MODE_MINUS: flush_tok = mk(TK_MINUS, 8'd0);
      default:    flush_v = 1'b0;
    endcase
  end

  // character seen between tokens
  logic  idle_v, idle_start;
  tok_t  idle_tok;
  mode_t idle_mode;
  always_comb begin
    idle_v     = 1'b1;
    idle_start = 1'b0;
    idle_mode  = MODE_IDLE;
    idle_tok   = mk(TK_ERROR, in_char);
    if (is_space(in_char)) begin
      idle_v = 1'b0;
    end else if (is_letter(in_char)) begin
      idle_v     = 1'b0;
      idle_start = 1'b1;
      idle_mode  = MODE_IDENT;
    end else if (is_digit(in_char)) begin
      idle_v     = 1'b0;
      idle_start = 1'b1;
      idle_mode  = MODE_NUMBER;
    end else begin
      case (in_char)
        CH_LPAREN: idle_tok = mk(TK_LPAREN, 8'd0);
        CH_RPAREN: idle_tok = mk(TK_RPAREN, 8'd0);
        CH_SEMI:   idle_tok = mk(TK_SEMI, 8'd0);
        CH_COMMA:  idle_tok = mk(TK_COMMA, 8'd0);
        CH_PLUS:   idle_tok = mk(TK_PLUS, 8'd0);
        CH_COLON: begin
          idle_v    = 1'b0;
          idle_mode = MODE_COLON;
        end
        CH_MINUS: begin
          idle_v    = 1'b0;
          idle_mode = MODE_MINUS;
        end
        default: idle_tok = mk(TK_ERROR, in_char);
      endcase
    end
  end

  // one scan step
  logic t0_v, t1_v, do_flush, do_idle, do_append;
  tok_t t0, t1, single;
  always_comb begin
    mode_nxt    = mode_r;
    run_len_nxt = run_len_r;
    prefix_nxt  = prefix_r;
    run_ovf_nxt = run_ovf_r;
    do_flush    = 1'b0;
    do_idle     = 1'b0;
    do_append   = 1'b0;
    single      = '0;
    t0_v        = 1'b0;
    t1_v        = 1'b0;
    t0          = flush_tok;
    t1          = idle_tok;

    if (in_end_of_input) begin
      mode_nxt    = MODE_IDLE;
      run_len_nxt = '0;
      prefix_nxt  = '0;
      run_ovf_nxt = 1'b0;
      t1          = mk(TK_EOF, 8'd0);
      t0_v        = flush_v;
      t1_v        = 1'b1;
    end else begin
      case (mode_r)
        MODE_IDENT: begin
          if (is_letter(in_char) || is_digit(in_char) || in_char == CH_UNDER) do_append = 1'b1;
          else do_flush = 1'b1;
        end
        MODE_NUMBER: begin
          if (is_digit(in_char)) do_append = 1'b1;
          else do_flush = 1'b1;
        end
        MODE_COLON: begin
          if (in_char == CH_EQUAL) begin
            mode_nxt = MODE_IDLE;
            single   = mk(TK_ASSIGN, 8'd0);
            t1_v     = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        MODE_MINUS: begin
          if (in_char == CH_MINUS) mode_nxt = MODE_COMMENT;
          else do_flush = 1'b1;
        end
        MODE_COMMENT: begin
          if (in_char == CH_NL) mode_nxt = MODE_IDLE;
        end
        default: do_idle = 1'b1;
      endcase

      if (single.kind == TK_ASSIGN) t1 = single;
      if (do_flush || do_idle) begin
        t0_v     = do_flush;
        t1_v     = idle_v;
        mode_nxt = idle_mode;
        if (idle_start) begin
          run_len_nxt = LEN_W'(1);
          prefix_nxt  = {{(KW_W-8){1'b0}}, in_char};
          run_ovf_nxt = 1'b0;
        end
      end
      if (do_append) begin
        if (run_len_r < LEN_W'(MAX_TOKEN_LEN)) begin
          for (int i = 0; i < KW_BYTES; i++) begin
            if (run_len_r == LEN_W'(i)) prefix_nxt[8*i +: 8] = in_char;
          end
          run_len_nxt = run_len_r + LEN_W'(1);
        end else begin
          run_ovf_nxt = 1'b1;
        end
      end
    end
    t0.last = !t1_v;
    t1.last = 1'b1;
  end

  logic [1:0] n_push;
  assign n_push    = in_acc ? (2'(t0_v) + 2'(t1_v)) : 2'd0;
  assign count_nxt = count_r + FIFO_CW'(n_push) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      run_len_r <= '0;
      prefix_r  <= '0;
      run_ovf_r <= 1'b0;
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      count_r   <= '0;
      kw_r[0]   <= KW_BEGIN_RST;
      kw_r[1]   <= KW_END_RST;
      kw_r[2]   <= KW_READ_RST;
      kw_r[3]   <= KW_WRITE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KW_BEGIN: kw_r[0] <= kw_text(cfg_data);
          CFG_KW_END:   kw_r[1] <= kw_text(cfg_data);
          CFG_KW_READ:  kw_r[2] <= kw_text(cfg_data);
          CFG_KW_WRITE: kw_r[3] <= kw_text(cfg_data);
          default: ;
        endcase
      end
      if (in_acc) begin
        mode_r    <= mode_nxt;
        run_len_r <= run_len_nxt;
        prefix_r  <= prefix_nxt;
        run_ovf_r <= run_ovf_nxt;
        wr_ptr_r  <= wr_ptr_r + FIFO_AW'(n_push);
      end
      if (pop) rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      count_r <= count_nxt;
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (t0_v) begin
        fifo_r[wr_ptr_r] <= t0;
        if (t1_v) fifo_r[wr_ptr_r + FIFO_AW'(1)] <= t1;
      end else if (t1_v) begin
        fifo_r[wr_ptr_r] <= t1;
      end
    end
  end

  tok_t head;
  assign head                = fifo_r[rd_ptr_r];
  assign out_valid           = (count_r != '0);
  assign out_token_kind      = head.kind;
  assign out_token_length    = head.len;
  assign out_bad_char        = head.bad;
  assign out_length_overflow = head.ovf;
  assign out_last            = head.last;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == TK_EOF |-> out_last)
    else $error("eof word without last");

  a_len_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_length != '0 |-> out_token_kind <= TK_INTLIT)
    else $error("length on non-run token");

  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_input |=> mode_r == MODE_IDLE && run_len_r == '0)
    else $error("scanner not idle after end of input");

endmodule

>>> sim/micro_language_tokenizer_test.sv
module micro_language_tokenizer_test import mlt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_NUMBER, LX_COLON, LX_MINUS, LX_COMMENT
  } lex_mode_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_char = 8'd0;
  logic             in_end_of_input = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [3:0]       out_token_kind;
  logic [LEN_W-1:0] out_token_length;
  logic [7:0]       out_bad_char;
  logic             out_length_overflow;
  logic             out_last;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = CFG_KW_BEGIN;
  logic [KW_W-1:0]  cfg_data = '0;

  // scanner shadow state
  lex_mode_e        lx_mode;
  logic [LEN_W-1:0] run_len;
  logic [KW_W-1:0]  run_head;
  logic             run_ovf;
  logic [KW_W-1:0]  kw_copy [NUM_KW];

  tok_t tokens_due [$];
  tok_t want, got;
  int   mismatches = 0;
  int   words_scanned = 0;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;

  micro_language_tokenizer dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [KW_W-1:0] kw_cut(input logic [KW_W-1:0] k);
    logic [KW_W-1:0] m;
    m = k;
    for (int i = KW_BYTES - 1; i >= 0; i--)
      if (k[8*i +: 8] == 8'd0) m = m & ((KW_W'(1) << (8 * i)) - 1'b1);
    return m;
  endfunction

  function automatic void push_token(input logic [3:0] kind, input logic [LEN_W-1:0] len,
                                     input logic [7:0] bad, input logic ovf);
    tok_t t;
    t.kind = kind;
    t.len  = len;
    t.bad  = bad;
    t.ovf  = ovf;
    t.last = 1'b0;
    tokens_due.push_back(t);
  endfunction

  function automatic void start_run();
    run_len  = '0;
    run_head = '0;
    run_ovf  = 1'b0;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    if (run_len < MAX_TOKEN_LEN) begin
      if (run_len < KW_BYTES) run_head[8*run_len +: 8] = c;
      run_len++;
    end else begin
      run_ovf = 1'b1;
    end
  endfunction

  function automatic logic [3:0] word_kind();
    if (run_len <= KW_BYTES && !run_ovf)
      for (int i = 0; i < NUM_KW; i++)
        if (run_head == kw_cut(kw_copy[i])) return 4'(i);
    return TK_IDENT;
  endfunction

  function automatic void flush_run();
    case (lx_mode)
      LX_IDENT:  push_token(word_kind(), run_len, 8'd0, run_ovf);
      LX_NUMBER: push_token(TK_INTLIT, run_len, 8'd0, run_ovf);
      LX_COLON:  push_token(TK_ERROR, '0, CH_COLON, 1'b0);
      LX_MINUS:  push_token(TK_MINUS, '0, 8'd0, 1'b0);
      default: ;
    endcase
    lx_mode = LX_IDLE;
  endfunction

  function automatic void idle_char(input logic [7:0] c);
    if (is_space(c)) return;
    if (is_letter(c) || is_digit(c)) begin
      start_run();
      take_char(c);
      if (is_letter(c)) lx_mode = LX_IDENT;
      else lx_mode = LX_NUMBER;
      return;
    end
    case (c)
      CH_LPAREN: push_token(TK_LPAREN, '0, 8'd0, 1'b0);
      CH_RPAREN: push_token(TK_RPAREN, '0, 8'd0, 1'b0);
      CH_SEMI:   push_token(TK_SEMI, '0, 8'd0, 1'b0);
      CH_COMMA:  push_token(TK_COMMA, '0, 8'd0, 1'b0);
      CH_PLUS:   push_token(TK_PLUS, '0, 8'd0, 1'b0);
      CH_COLON:  lx_mode = LX_COLON;
      CH_MINUS:  lx_mode = LX_MINUS;
      default:   push_token(TK_ERROR, '0, c, 1'b0);
    endcase
  endfunction

  // tokens caused by one accepted word, appended to tokens_due
  function automatic void lex_word(input logic [7:0] c, input logic eoi);
    int   mark;
    tok_t t;
    mark = tokens_due.size();
    if (eoi) begin
      if (lx_mode == LX_COMMENT) lx_mode = LX_IDLE;
      flush_run();
      push_token(TK_EOF, '0, 8'd0, 1'b0);
      start_run();
    end else begin
      case (lx_mode)
        LX_IDENT:
          if (is_letter(c) || is_digit(c) || c == CH_UNDER) take_char(c);
          else begin
            flush_run();
            idle_char(c);
          end
        LX_NUMBER:
          if (is_digit(c)) take_char(c);
          else begin
            flush_run();
            idle_char(c);
          end
        LX_COLON:
          if (c == CH_EQUAL) begin
            push_token(TK_ASSIGN, '0, 8'd0, 1'b0);
            lx_mode = LX_IDLE;
          end else begin
            flush_run();
            idle_char(c);
          end
        LX_MINUS:
          if (c == CH_MINUS) lx_mode = LX_COMMENT;
          else begin
            flush_run();
            idle_char(c);
          end
        LX_COMMENT:
          if (c == CH_NL) lx_mode = LX_IDLE;
        default:
          idle_char(c);
      endcase
    end
    if (tokens_due.size() > mark) begin
      t = tokens_due.pop_back();
      t.last = 1'b1;
      tokens_due.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = {out_token_kind, out_token_length, out_bad_char, out_length_overflow, out_last};
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected token kind %0d len %0d bad %h ovf %b last %b",
                   $time, got.kind, got.len, got.bad, got.ovf, got.last);
      end else begin
        want = tokens_due.pop_front();
        if (got.kind !== want.kind || got.len !== want.len || got.bad !== want.bad ||
            got.ovf !== want.ovf || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: token mismatch: expected kind %0d len %0d bad %h ovf %b last %b, %s",
                     $time, want.kind, want.len, want.bad, want.ovf, want.last,
                     $sformatf("got kind %0d len %0d bad %h ovf %b last %b",
                               got.kind, got.len, got.bad, got.ovf, got.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_word(input logic [7:0] ch, input logic eoi);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char         <= ch;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_scanned++;
    lex_word(ch, eoi);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic pause_until_drained(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // only while idle: after pause_until_drained
  task automatic load_keywords(input logic [KW_W-1:0] k_begin, k_end, k_read, k_write);
    logic [KW_W-1:0] vals [NUM_KW];
    logic [2:0]      regs [NUM_KW];
    vals = '{k_begin, k_end, k_read, k_write};
    regs = '{CFG_KW_BEGIN, CFG_KW_END, CFG_KW_READ, CFG_KW_WRITE};
    for (int i = 0; i < NUM_KW; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      kw_copy[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return 8'("a" + $urandom_range(25));
    return 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(62);
    if (r < 52) return rand_letter();
    if (r < 62) return 8'("0" + $urandom_range(9));
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(5);
    if (r == 0) return " ";
    return 8'(8 + r);
  endfunction

  function automatic logic [KW_W-1:0] rand_keyword();
    logic [KW_W-1:0] k;
    int              n, pick;
    k    = '0;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 14) return '1;
    n = $urandom_range(KW_BYTES, 1);
    k[7:0] = rand_letter();
    for (int i = 1; i < n; i++) k[8*i +: 8] = rand_word_char();
    // junk after a zero byte must not count
    if (pick < 24 && n < KW_BYTES - 1) k[KW_W-1 -: 8] = rand_letter();
    return k;
  endfunction

  task automatic send_piece();
    int              pick, n;
    logic [KW_W-1:0] kw;
    logic [7:0]      b;
    pick = $urandom_range(99);
    if (pick < 22) begin
      if ($urandom_range(2) == 0) begin
        kw = kw_copy[$urandom_range(NUM_KW - 1)];
        if (kw[7:0] == 8'd0) send_word(rand_letter(), 1'b0);
        for (int i = 0; i < KW_BYTES && kw[8*i +: 8] != 8'd0; i++)
          send_word(kw[8*i +: 8], 1'b0);
      end else begin
        n = ($urandom_range(39) == 0) ? $urandom_range(40, 30) : $urandom_range(8, 1);
        send_word(rand_letter(), 1'b0);
        repeat (n - 1) send_word(rand_word_char(), 1'b0);
      end
    end else if (pick < 36) begin
      n = ($urandom_range(39) == 0) ? $urandom_range(36, 31) : $urandom_range(6, 1);
      repeat (n) send_word(8'("0" + $urandom_range(9)), 1'b0);
    end else if (pick < 60) begin
      case ($urandom_range(6))
        0: send_word(CH_LPAREN, 1'b0);
        1: send_word(CH_RPAREN, 1'b0);
        2: send_word(CH_SEMI, 1'b0);
        3: send_word(CH_COMMA, 1'b0);
        4: send_word(CH_PLUS, 1'b0);
        5: send_word(CH_MINUS, 1'b0);
        default: begin
          send_word(CH_COLON, 1'b0);
          send_word(CH_EQUAL, 1'b0);
        end
      endcase
    end else if (pick < 70) begin
      send_word(rand_space(), 1'b0);
    end else if (pick < 77) begin
      send_word(CH_MINUS, 1'b0);
      send_word(CH_MINUS, 1'b0);
      repeat ($urandom_range(6)) begin
        b = 8'($urandom);
        send_word((b == CH_NL) ? CH_PLUS : b, 1'b0);
      end
      if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b1);
      else send_word(CH_NL, 1'b0);
    end else if (pick < 82) begin
      send_word(CH_COLON, 1'b0);
    end else if (pick < 92) begin
      send_word(8'($urandom), 1'b0);
    end else if (pick < 96) begin
      send_word(8'($urandom), 1'b1);
    end else begin
      send_word(8'($urandom_range(255, 128)), 1'b0);
    end
    // no separator half the time, so a delimiter closes the pending token
    if ($urandom_range(1)) send_word(rand_space(), 1'b0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_operators();
    // '-x' splits to minus + ident, ')' closes the ident, ':(' is a lone colon
    send_str("(),;+:=:(-xZ9_)09\t");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    pause_until_drained(0);
  endtask

  task automatic test_special_cases();
    send_word(CH_COLON, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(CH_MINUS, 1'b0);
    send_word(8'hFF, 1'b1);
    send_str("--c\n+");
    send_str("--");
    send_word(8'h80, 1'b0);
    send_word(8'hA5, 1'b1);   // end inside a comment: eof only
    send_str("end");
    send_word(8'h5A, 1'b1);
    pause_until_drained(8);
  endtask

  task automatic test_keywords();
    logic [KW_W-1:0] ab_cd;
    ab_cd = {"d", "c", 8'h00, "b", "a"};
    // "ab" twice: lower index wins; empty and all-ones never match
    load_keywords(ab_cd, {24'd0, "b", "a"}, '0, '1);
    send_str("ab a;abc,");
    send_word(8'h00, 1'b1);
    pause_until_drained(8);
    load_keywords({"z", "z", "z", "z", "z"}, {32'd0, "Q"}, {16'd0, "9", "_", "x"},
                  {"C", "2", "b", "1", "A"});
    send_str("zzzzz zzzzzz zzzz Q x_9+A1b2C");
    send_word(8'h00, 1'b1);
    pause_until_drained(8);
  endtask

  task automatic test_long_tokens();
    repeat (MAX_TOKEN_LEN) send_word(rand_word_char(), 1'b0);
    send_word(" ", 1'b0);
    repeat (MAX_TOKEN_LEN + 1) send_word(8'("0" + $urandom_range(9)), 1'b0);
    send_word(CH_SEMI, 1'b0);
    send_word(rand_letter(), 1'b0);
    repeat (MAX_TOKEN_LEN + 7) send_word(rand_word_char(), 1'b0);
    send_word(8'h00, 1'b1);
    pause_until_drained(8);
  endtask

  task automatic test_random_text(input int target);
    int stop_at;
    stop_at = words_scanned + target;
    while (words_scanned < stop_at) begin
      send_piece();
      if ($urandom_range(299) == 0) pause_until_drained(0);
    end
    send_word(8'($urandom), 1'b1);
    pause_until_drained(8);
  endtask

  initial begin
    logic [KW_W-1:0] kw_pick;
    lx_mode = LX_IDLE;
    start_run();
    kw_copy = '{KW_BEGIN_RST, KW_END_RST, KW_READ_RST, KW_WRITE_RST};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = 25;
    recv_stall_pct = 87;
    test_operators();
    test_special_cases();
    test_keywords();
    test_long_tokens();
    load_keywords(KW_BEGIN_RST, KW_END_RST, KW_READ_RST, KW_WRITE_RST);
    test_random_text(350);

    send_gap_pct   = 87;
    recv_stall_pct = 25;
    load_keywords(rand_keyword(), rand_keyword(), rand_keyword(), rand_keyword());
    test_random_text(350);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    kw_pick = rand_keyword();
    load_keywords(kw_pick, rand_keyword(), kw_pick, '0);
    test_random_text(350);

    pause_until_drained(16);
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
rtl/mlt_pkg.sv
rtl/micro_language_tokenizer.sv
sim/micro_language_tokenizer_test.sv
